// File: rtl/cis_pkg.sv
// Shared types and constants for the chained idiom scanner.
package cis_pkg;

    localparam int unsigned HIST_LEN = 13;

    localparam logic [7:0]  OP_LEA       = 8'h8d;
    localparam logic [7:0]  OP_MOV       = 8'h8b;
    localparam logic [7:0]  MOD_MASK     = 8'hc0;
    localparam logic [7:0]  MOD_DISP32   = 8'h80;
    localparam logic [7:0]  MOD_NODISP   = 8'h00;
    localparam logic [2:0]  RM_SIB       = 3'h4;
    localparam logic [2:0]  RM_DISPONLY  = 3'h5;
    localparam logic [31:0] ANCHOR_RESET = 32'h0000_0c58;

    typedef enum logic [1:0] {
        OUT_NONE   = 2'd0,
        OUT_UNIQUE = 2'd1,
        OUT_AMBIG  = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } t_scan_req;

    typedef struct packed {
        t_outcome           outcome;
        logic signed [31:0] found_disp;
        logic [23:0]        site_total;
        logic [2:0]         distinct_total;
        logic               set_overflowed;
    } t_scan_rsp;

    // One classified byte position handed from front to back.
    typedef struct packed {
        logic        hit;
        logic [31:0] disp;
        logic        last;
    } t_cis_entry;

endpackage

// File: rtl/cis_front.sv
// Front end: byte window shift line and idiom classifier.
module cis_front
    import cis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_scan_req   i_req,
    input  logic [31:0] i_anchor,
    output t_cis_entry  o_entry
);

    logic [7:0] r_win [HIST_LEN];
    logic [3:0] r_fill;
    logic [3:0] n_fill;
    logic [7:0] w [HIST_LEN+1];
    logic       hit;

    always_comb begin
        for (int k = 0; k < HIST_LEN; k++) begin
            w[k] = r_win[k];
        end
        w[HIST_LEN] = i_req.code_byte;
    end

    always_comb begin
        hit = (r_fill == 4'(HIST_LEN));
        // lea r1,[b+disp32]
        if (w[0] != OP_LEA) hit = 1'b0;
        if ((w[1] & MOD_MASK) != MOD_DISP32 || w[1][2:0] == RM_SIB) hit = 1'b0;
        // mov r2,[r1]
        if (w[6] != OP_MOV) hit = 1'b0;
        if ((w[7] & MOD_MASK) != MOD_NODISP || w[7][2:0] == RM_SIB ||
            w[7][2:0] == RM_DISPONLY) hit = 1'b0;
        // mov r3,[r2+anchor]
        if (w[8] != OP_MOV) hit = 1'b0;
        if ((w[9] & MOD_MASK) != MOD_DISP32 || w[9][2:0] == RM_SIB) hit = 1'b0;
        if ({w[13], w[12], w[11], w[10]} != i_anchor) hit = 1'b0;
        // register chaining
        if (w[1][5:3] != w[7][2:0]) hit = 1'b0;
        if (w[7][5:3] != w[9][2:0]) hit = 1'b0;
    end

    assign o_entry.hit  = hit;
    assign o_entry.disp = {w[5], w[4], w[3], w[2]};
    assign o_entry.last = i_req.last_byte;

    always_comb begin
        n_fill = r_fill;
        if (i_accept) begin
            if (i_req.last_byte) begin
                n_fill = '0;
            end else if (r_fill != 4'(HIST_LEN)) begin
                n_fill = r_fill + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Stale bytes after a span end are masked by the fill count.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int k = 0; k < HIST_LEN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[HIST_LEN-1] <= i_req.code_byte;
        end
    end

endmodule

// File: rtl/cis_queue.sv
// Two-entry queue between the classifier and the recording back end.
module cis_queue
    import cis_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cis_entry i_entry,
    input  logic       i_pop,
    output t_cis_entry o_head,
    output logic       o_full,
    output logic       o_empty
);

    t_cis_entry r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

// File: rtl/cis_back.sv
// Back end: site counting, distinct displacement set and result register.
module cis_back
    import cis_pkg::*;
#(
    parameter int unsigned MAX_DISTINCT = 4
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cis_entry i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output t_scan_rsp  o_rsp
);

    localparam int unsigned UW = $clog2(MAX_DISTINCT + 1);

    logic [23:0]       r_sites;
    logic [UW-1:0]     r_used;
    logic              r_ovf;
    logic [31:0]       r_seen [MAX_DISTINCT];
    logic              r_valid;
    t_scan_rsp         r_rsp;

    logic [23:0]       n_sites;
    logic [UW-1:0]     n_used;
    logic              n_ovf;
    logic              n_valid;
    t_scan_rsp         n_rsp;
    logic              seen_hit;
    logic              insert;
    logic [31:0]       first_disp;
    logic [4:0]        used_ext;

    assign o_pop   = !i_empty && !(i_head.last && r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        seen_hit = 1'b0;
        for (int k = 0; k < MAX_DISTINCT; k++) begin
            if (UW'(k) < r_used && r_seen[k] == i_head.disp) seen_hit = 1'b1;
        end
    end

    always_comb begin
        insert  = 1'b0;
        n_sites = r_sites;
        n_used  = r_used;
        n_ovf   = r_ovf;
        if (i_head.hit) begin
            if (r_sites != '1) n_sites = r_sites + 24'd1;
            if (!seen_hit) begin
                if (r_used < UW'(MAX_DISTINCT)) begin
                    insert = 1'b1;
                    n_used = r_used + UW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
        first_disp = (insert && r_used == '0) ? i_head.disp : r_seen[0];
        used_ext   = 5'(n_used);

        n_rsp.site_total     = n_sites;
        n_rsp.distinct_total = (used_ext > 5'd7) ? 3'd7 : used_ext[2:0];
        n_rsp.set_overflowed = n_ovf;
        n_rsp.found_disp     = '0;
        if (n_sites == '0) begin
            n_rsp.outcome = OUT_NONE;
        end else if (n_used == UW'(1) && !n_ovf) begin
            // a lone zero displacement counts as not found
            if (first_disp != '0) begin
                n_rsp.outcome    = OUT_UNIQUE;
                n_rsp.found_disp = first_disp;
            end else begin
                n_rsp.outcome = OUT_NONE;
            end
        end else begin
            n_rsp.outcome = OUT_AMBIG;
        end

        n_valid = r_valid && i_stall;
        if (o_pop && i_head.last) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sites <= '0;
            r_used  <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                if (i_head.last) begin
                    r_sites <= '0;
                    r_used  <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_sites <= n_sites;
                    r_used  <= n_used;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) r_rsp <= n_rsp;
        if (o_pop && insert) begin
            for (int k = 0; k < MAX_DISTINCT; k++) begin
                if (UW'(k) == r_used) r_seen[k] <= i_head.disp;
            end
        end
    end

endmodule

// File: rtl/chained_idiom_scan.sv
// Chained lea/mov/mov idiom scanner, top level.
//
// Input channel: one code byte per request (i_req.code_byte), with
// i_req.last_byte marking the final byte of a span. A request is taken when
// i_valid is high and o_stall is low. Output channel: one result per span,
// taken when o_valid is high and i_stall is low.
// Each byte closes a 14-byte window that is classified in the front end and
// queued; the back end counts matching sites and collects up to MAX_DISTINCT
// distinct lea displacements. On the last byte the result is registered and
// all scan state is cleared for the next span.
// Throughput: one byte per cycle while o_stall is low. The result is
// registered by the back end once the last byte has been classified as it
// is taken, queued, and recorded when it reaches the head of the queue
// behind any bytes still waiting ahead of it.
// A stalled result holds; meanwhile bytes of the next span keep flowing
// until a second last byte reaches the head of the two-entry queue, after
// which o_stall rises once the queue fills.
// Reset clears the counts, queue and output; r_anchor returns to 3160.
// The anchor register is written through i_cfg_wr_en / i_cfg_wr_data; the
// user must do so only while the block is idle, which the block does not enforce.
module chained_idiom_scan
    import cis_pkg::*;
#(
    parameter int unsigned MAX_DISTINCT = 4
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_scan_req   i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_scan_rsp   o_rsp,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    logic [31:0] r_anchor;
    logic        accept;
    logic        q_full;
    logic        q_empty;
    logic        pop;
    t_cis_entry  front_entry;
    t_cis_entry  head_entry;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor <= ANCHOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_anchor <= i_cfg_wr_data;
        end
    end

    cis_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_anchor (r_anchor),
        .o_entry  (front_entry)
    );

    cis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cis_back #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    a_unique_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.outcome == OUT_UNIQUE |-> o_rsp.found_disp != '0)
        else $error("unique result with zero displacement");

    a_disp_only_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.outcome != OUT_UNIQUE |-> o_rsp.found_disp == '0)
        else $error("displacement reported without unique outcome");

    a_sites_need_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.site_total != '0 |-> o_rsp.distinct_total != '0)
        else $error("sites counted but no displacement recorded");

    a_no_sites_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.site_total == '0 |->
            o_rsp.outcome == OUT_NONE && !o_rsp.set_overflowed)
        else $error("empty span reported a match");

    a_last_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && head_entry.last |=> o_valid)
        else $error("span end popped without a result");

endmodule
